// File: rtl/core/uer_pkg.sv
package uer_pkg;

    // Timer width default
    localparam int TIMER_BITS_DEF = 16;

    // Configuration register widths
    localparam int TRIG_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int CM_W      = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM = 2'd3;

    // Configuration reset values
    localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 10'd2;
    localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [CM_W-1:0]      US_PER_CM_RST = 8'd58;

    // Largest distance count
    localparam logic [CM_W-1:0] CM_MAX = 8'd255;

    // Measurement phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LOW  = 3'd1,
        PH_HIGH = 3'd2,
        PH_RISE = 3'd3,
        PH_FALL = 3'd4
    } phase_t;

endpackage

// File: rtl/core/ultrasonic_echo_ranger.sv
// Echo ranger for a trigger/echo ultrasonic distance sensor.
// Input stream: one transfer per microsecond tick, carrying a start request
// and the sampled echo pin level. Output stream: one transfer per input
// transfer, carrying the trigger pin level, busy, done, ok and the distance
// in centimetres (last finished result between measurements).
// A start from idle holds trigger low (unless its time is zero), then
// drives the trigger pulse, then times the echo high interval, counting one
// centimetre every us_per_cm ticks (saturating at 255). Each echo phase
// uses the same timeout; a timeout finishes with ok low and distance zero.
// An input transfer passes the input register, then the result register,
// on its way to the output. Throughput: one tick per cycle while the
// receiver accepts, set by the phase/counter update between the registers.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops; no tick is lost or repeated.
// Configuration writes (cfg_we) take effect at the next edge and are meant
// to be made only while no measurement is running.
// Reset (rst_n low, asynchronous) empties both registers, returns the
// sequencer to idle, clears counters and the last distance, and restores
// the default configuration.
module ultrasonic_echo_ranger #(
    parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: [0] start_req, [1] echo, [7:2] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [uer_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: [0] trigger, [1] busy_res, [2] done_res, [3] ok,
    //          [11:4] distance_cm, [15:12] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [uer_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]         cfg_data
);
    import uer_pkg::*;

    localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TICK_ONE = TIMER_BITS'(1);

    // Configuration registers
    logic [TRIG_W-1:0]    trig_low_reg;
    logic [TRIG_W-1:0]    trig_high_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CM_W-1:0]      us_per_cm_reg;

    // Pipeline registers
    logic       in_valid_reg;
    logic       start_reg;
    logic       echo_reg;
    logic       out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // Measurement state
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] ticks_reg, ticks_next;
    logic [CM_W-1:0]       sub_reg, sub_next;
    logic [CM_W-1:0]       cnt_reg, cnt_next;
    logic [CM_W-1:0]       dist_reg, dist_next;

    logic       out_ready;
    logic       fire;
    logic       trig_o, busy_o, done_o, ok_o;
    logic [TIMER_BITS-1:0] tick_inc;
    logic [CMP_W-1:0]      limit;
    logic                  reached;
    logic [CM_W-1:0]       sub_base, cnt_base, sub_inc, sub_echo, cnt_echo;

    // Handshake control
    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg  <= TRIG_LOW_RST;
            trig_high_reg <= TRIG_HIGH_RST;
            timeout_reg   <= TIMEOUT_RST;
            us_per_cm_reg <= US_PER_CM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIG_LOW:  trig_low_reg  <= cfg_data[TRIG_W-1:0];
                REG_TRIG_HIGH: trig_high_reg <= cfg_data[TRIG_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                REG_US_PER_CM: us_per_cm_reg <= cfg_data[CM_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase tick counter, saturating, and its limit check
    always_comb
    begin
        tick_inc = (ticks_reg != TICK_MAX) ? ticks_reg + TICK_ONE : ticks_reg;
        case (phase_reg)
            PH_LOW:  limit = CMP_W'(trig_low_reg);
            PH_HIGH: limit = CMP_W'(trig_high_reg);
            default: limit = CMP_W'(timeout_reg);
        endcase
        reached = (CMP_W'(tick_inc) >= limit) || (tick_inc == TICK_MAX);
    end

    // Centimetre counting for one echo-high tick
    always_comb
    begin
        sub_base = (phase_reg == PH_RISE) ? '0 : sub_reg;
        cnt_base = (phase_reg == PH_RISE) ? '0 : cnt_reg;
        sub_inc  = sub_base + 8'd1;
        if (sub_inc >= us_per_cm_reg)
        begin
            sub_echo = '0;
            cnt_echo = (cnt_base < CM_MAX) ? cnt_base + 8'd1 : cnt_base;
        end
        else
        begin
            sub_echo = sub_inc;
            cnt_echo = cnt_base;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        sub_next   = sub_reg;
        cnt_next   = cnt_reg;
        dist_next  = dist_reg;
        case (phase_reg)
            PH_LOW:
            begin
                ticks_next = tick_inc;
                if (reached)
                begin
                    phase_next = PH_HIGH;
                    ticks_next = '0;
                end
            end
            PH_HIGH:
            begin
                ticks_next = tick_inc;
                if (reached)
                begin
                    phase_next = PH_RISE;
                    ticks_next = '0;
                end
            end
            PH_RISE:
            begin
                if (echo_reg)
                begin
                    // first echo tick counts; the fall timer starts at one
                    phase_next = PH_FALL;
                    ticks_next = TICK_ONE;
                    sub_next   = sub_echo;
                    cnt_next   = cnt_echo;
                end
                else
                begin
                    ticks_next = tick_inc;
                    if (reached)
                    begin
                        phase_next = PH_IDLE;
                        dist_next  = '0;
                    end
                end
            end
            PH_FALL:
            begin
                if (!echo_reg)
                begin
                    phase_next = PH_IDLE;
                    dist_next  = cnt_reg;
                end
                else
                begin
                    sub_next   = sub_echo;
                    cnt_next   = cnt_echo;
                    ticks_next = tick_inc;
                    if (reached)
                    begin
                        phase_next = PH_IDLE;
                        dist_next  = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start_reg)
                begin
                    phase_next = (trig_low_reg != '0) ? PH_LOW : PH_HIGH;
                    ticks_next = '0;
                    sub_next   = '0;
                    cnt_next   = '0;
                end
            end
        endcase
    end

    // Result flags
    always_comb
    begin
        trig_o = 1'b0;
        busy_o = 1'b1;
        done_o = 1'b0;
        ok_o   = 1'b0;
        case (phase_reg)
            PH_LOW:  ;
            PH_HIGH: trig_o = 1'b1;
            PH_RISE: done_o = !echo_reg && reached;
            PH_FALL:
            begin
                done_o = !echo_reg || reached;
                ok_o   = !echo_reg;
            end
            default: busy_o = start_reg;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            start_reg <= s_tdata[0];
            echo_reg  <= s_tdata[1];
        end
    end

    // Sequencer state, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            sub_reg   <= '0;
            cnt_reg   <= '0;
            dist_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            sub_reg   <= sub_next;
            cnt_reg   <= cnt_next;
            dist_reg  <= dist_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= {4'b0000, dist_next, ok_o, done_o, busy_o, trig_o};
    end

endmodule

// File: rtl/core/uer_checker.sv
module uer_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [uer_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import uer_pkg::*;

    // A stalled result transfer holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // ok only comes with done
    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("ok without done");

    // done and trigger only while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2] || m_tdata[0]) |-> m_tdata[1])
        else $error("done or trigger while not busy");

    // a timed-out measurement reports zero distance
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] && !m_tdata[3] |-> m_tdata[11:4] == '0)
        else $error("nonzero distance on timeout");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
